### sv/ramr_pkg.sv
// Package for the rational add/multiply/reduce block.
// Holds the widths, kind codes, transaction structs and operand conditioning.
// No dependencies.
package ramr_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int MAG_W         = OPERAND_WIDTH - 1;
    localparam int PROD_W        = 2 * MAG_W;
    localparam int WIDE_W        = 64;
    localparam int DEN_W         = 62;
    localparam int CNT_W         = 7;
    localparam int SHIFT_W       = 6;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_MUL = 2'd1;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [FIELD_W-1:0] left_num;
        logic signed [FIELD_W-1:0] left_den;
        logic signed [FIELD_W-1:0] right_num;
        logic signed [FIELD_W-1:0] right_den;
    } cmd_t;

    typedef struct packed {
        logic signed [WIDE_W-1:0] result_num;
        logic [DEN_W-1:0]         result_den;
    } res_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } opnd_t;

    // Sign and magnitude after clipping to +-(2^(OPERAND_WIDTH-1) - 1).
    function automatic opnd_t take_operand(input logic signed [FIELD_W-1:0] v);
        logic signed [FIELD_W:0] lim;
        logic signed [FIELD_W:0] s;
        logic signed [FIELD_W:0] m;
        opnd_t o;
        lim = ((FIELD_W+1)'(1) <<< MAG_W) - (FIELD_W+1)'(1);
        s   = (FIELD_W+1)'(v);
        if (s > lim)
            s = lim;
        if (s < -lim)
            s = -lim;
        o.neg = s[FIELD_W];
        m     = o.neg ? -s : s;
        o.mag = m[MAG_W-1:0];
        return o;
    endfunction

    // A zero denominator stands for one.
    function automatic opnd_t fix_den(input opnd_t o);
        opnd_t r;
        r = o;
        if (o.mag == '0)
        begin
            r.neg = 1'b0;
            r.mag = MAG_W'(1);
        end
        return r;
    endfunction

endpackage

### sv/rational_add_mul_reduce.sv
// Rational add / multiply / normalize with GCD reduction, top level.
// Depends on ramr_pkg.
//
// Usage: drive cmd and raise start while busy is low; the transaction is
// taken at that clock edge and busy rises. Kind add gives ln*rd + ld*rn over
// ld*rd, kind multiply ln*rn over ld*rd, any other kind reduces the left
// fraction alone. The result leaves reduced, sign on the numerator, on the
// result port, marked by result_valid for exactly one cycle.
// Steps from the accepting edge: shift-add multiplies
// (three for add, two for multiply, none for normalize), a combine step,
// a binary GCD (one 64-bit subtract or shift a cycle), and restoring
// division of the numerator, then the denominator, by the GCD. One
// transaction at a time.
// busy falls in the cycle result_valid is shown, so a new start may be taken
// then. The receiver cannot stall; results are not held.
// Reset (rst_n low, asynchronous) returns to idle and drops any transaction
// in flight.
module rational_add_mul_reduce
    import ramr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic result_valid,
    output res_t result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_COMB,
        ST_GCD,
        ST_DIV
    } state_t;

    state_t state_reg;

    logic [1:0]        kind_reg;
    opnd_t             a_reg, b_reg, c_reg, d_reg;
    logic [1:0]        idx_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] mcand_reg;
    logic [MAG_W-1:0]  mplier_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic              nneg_reg, mneg_reg;
    logic [WIDE_W-1:0] un_reg, um_reg;
    logic [WIDE_W-1:0] x_reg, y_reg;
    logic [SHIFT_W-1:0] k_reg;
    logic [WIDE_W-1:0] g_reg;
    logic [WIDE_W-1:0] dvd_reg, rem_reg;
    logic              dsel_reg;
    logic [WIDE_W-1:0] qn_reg;
    logic              valid_reg;
    res_t              result_reg;

    // operand pair for each product
    logic [MAG_W-1:0] opx, opy;
    always_comb
    begin
        opx = '0;
        opy = '0;
        case (idx_reg)
            2'd0:
            begin
                opx = a_reg.mag;
                opy = (kind_reg == KIND_ADD) ? d_reg.mag : c_reg.mag;
            end
            2'd1:
            begin
                opx = b_reg.mag;
                opy = c_reg.mag;
            end
            default:
            begin
                opx = b_reg.mag;
                opy = d_reg.mag;
            end
        endcase
    end

    // combine products into signed numerator and denominator magnitudes
    logic [WIDE_W-1:0] s0, s1, nsum, nmag;
    logic              ncomb_neg, mcomb_neg;
    logic [WIDE_W-1:0] mcomb;
    always_comb
    begin
        s0 = (a_reg.neg ^ d_reg.neg) ? -WIDE_W'(p0_reg) : WIDE_W'(p0_reg);
        s1 = (b_reg.neg ^ c_reg.neg) ? -WIDE_W'(p1_reg) : WIDE_W'(p1_reg);
        nsum = s0 + s1;
        if (kind_reg == KIND_ADD)
        begin
            ncomb_neg = nsum[WIDE_W-1];
            nmag      = ncomb_neg ? -nsum : nsum;
            mcomb_neg = b_reg.neg ^ d_reg.neg;
            mcomb     = WIDE_W'(p2_reg);
        end
        else if (kind_reg == KIND_MUL)
        begin
            ncomb_neg = a_reg.neg ^ c_reg.neg;
            nmag      = WIDE_W'(p0_reg);
            mcomb_neg = b_reg.neg ^ d_reg.neg;
            mcomb     = WIDE_W'(p2_reg);
        end
        else
        begin
            ncomb_neg = a_reg.neg;
            nmag      = WIDE_W'(a_reg.mag);
            mcomb_neg = b_reg.neg;
            mcomb     = WIDE_W'(b_reg.mag);
        end
    end

    // restoring division step
    logic [WIDE_W-1:0] rem_sh, rem_sub;
    logic              q_bit;
    always_comb
    begin
        rem_sh  = {rem_reg[WIDE_W-2:0], dvd_reg[WIDE_W-1]};
        q_bit   = (rem_sh >= g_reg);
        rem_sub = q_bit ? rem_sh - g_reg : rem_sh;
    end

    logic [WIDE_W-1:0] qn_fin, qm_fin;
    logic              neg_fin;
    assign qn_fin  = qn_reg;
    assign qm_fin  = {dvd_reg[WIDE_W-2:0], q_bit};
    assign neg_fin = (nneg_reg != mneg_reg) && (un_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg   <= cmd.kind;
                        a_reg      <= take_operand(cmd.left_num);
                        b_reg      <= fix_den(take_operand(cmd.left_den));
                        c_reg      <= take_operand(cmd.right_num);
                        d_reg      <= fix_den(take_operand(cmd.right_den));
                        idx_reg    <= 2'd0;
                        cnt_reg    <= '0;
                        acc_reg    <= '0;
                        p1_reg     <= '0;
                        // load happens on first MUL cycle via cnt == 0
                        if (cmd.kind == KIND_ADD || cmd.kind == KIND_MUL)
                            state_reg <= ST_MUL;
                        else
                            state_reg <= ST_COMB;
                    end
                end
                ST_MUL:
                begin
                    if (cnt_reg == '0)
                    begin
                        mcand_reg  <= PROD_W'(opx);
                        mplier_reg <= opy;
                        acc_reg    <= '0;
                        cnt_reg    <= CNT_W'(1);
                    end
                    else
                    begin
                        if (mplier_reg[0])
                            acc_reg <= acc_reg + mcand_reg;
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                        if (cnt_reg == CNT_W'(MAG_W))
                        begin
                            cnt_reg <= '0;
                            case (idx_reg)
                                2'd0: p0_reg <= mplier_reg[0] ? acc_reg + mcand_reg
                                                              : acc_reg;
                                2'd1: p1_reg <= mplier_reg[0] ? acc_reg + mcand_reg
                                                              : acc_reg;
                                default: p2_reg <= mplier_reg[0] ? acc_reg + mcand_reg
                                                                 : acc_reg;
                            endcase
                            if (idx_reg == 2'd2)
                                state_reg <= ST_COMB;
                            else if (idx_reg == 2'd0 && kind_reg != KIND_ADD)
                                idx_reg <= 2'd2;
                            else
                                idx_reg <= idx_reg + 2'd1;
                        end
                        else
                            cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_COMB:
                begin
                    nneg_reg  <= ncomb_neg;
                    mneg_reg  <= mcomb_neg;
                    un_reg    <= nmag;
                    um_reg    <= mcomb;
                    x_reg     <= nmag;
                    y_reg     <= mcomb;
                    k_reg     <= '0;
                    state_reg <= ST_GCD;
                end
                ST_GCD:
                begin
                    // binary GCD; denominator is never zero so g >= 1
                    if (x_reg == '0 || y_reg == '0)
                    begin
                        g_reg     <= (x_reg | y_reg) << k_reg;
                        dvd_reg   <= un_reg;
                        rem_reg   <= '0;
                        dsel_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                    else if (!x_reg[0] && !y_reg[0])
                    begin
                        x_reg <= x_reg >> 1;
                        y_reg <= y_reg >> 1;
                        k_reg <= k_reg + SHIFT_W'(1);
                    end
                    else if (!x_reg[0])
                        x_reg <= x_reg >> 1;
                    else if (!y_reg[0])
                        y_reg <= y_reg >> 1;
                    else if (x_reg >= y_reg)
                        x_reg <= x_reg - y_reg;
                    else
                        y_reg <= y_reg - x_reg;
                end
                ST_DIV:
                begin
                    rem_reg <= rem_sub;
                    dvd_reg <= {dvd_reg[WIDE_W-2:0], q_bit};
                    if (cnt_reg == CNT_W'(WIDE_W - 1))
                    begin
                        cnt_reg <= '0;
                        if (!dsel_reg)
                        begin
                            qn_reg   <= qm_fin;
                            dvd_reg  <= um_reg;
                            rem_reg  <= '0;
                            dsel_reg <= 1'b1;
                        end
                        else
                        begin
                            result_reg.result_num <= neg_fin ? -qn_fin : qn_fin;
                            result_reg.result_den <= qm_fin[DEN_W-1:0];
                            valid_reg             <= 1'b1;
                            state_reg             <= ST_IDLE;
                        end
                    end
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after accepted transaction");
    a_valid_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg) == ST_DIV)
        else $error("result strobe outside division end");
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.result_den != '0)
        else $error("zero denominator in result");
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> g_reg != '0)
        else $error("zero divisor");
`endif

endmodule

### tb/tb_top.sv
// Testbench for rational_add_mul_reduce: directed table, then random transactions,
// each checked against a behavioral predictor of the reduced fraction.
// Depends on ramr_pkg and the rational_add_mul_reduce RTL.
module tb_top;
    import ramr_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic result_valid;
    res_t result;

    int   errors;
    int   n_sent;
    int   n_checked;
    int   idle_pct;
    res_t fraction_q[$];

    rational_add_mul_reduce u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("timeout");
        $display("tb_top failed");
        $finish;
    end

    function automatic logic signed [63:0] clip_operand(input logic signed [31:0] v);
        logic signed [63:0] s;
        logic signed [63:0] lim;
        lim = (64'sd1 <<< (OPERAND_WIDTH - 1)) - 64'sd1;
        s   = 64'(v);
        if (s > lim)
            s = lim;
        if (s < -lim)
            s = -lim;
        return s;
    endfunction

    function automatic res_t reduce_fraction(input cmd_t c);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] rc;
        logic signed [63:0] d;
        logic signed [63:0] n;
        logic signed [63:0] m;
        logic [63:0] un;
        logic [63:0] um;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        res_t r;
        a  = clip_operand(c.left_num);
        b  = clip_operand(c.left_den);
        rc = clip_operand(c.right_num);
        d  = clip_operand(c.right_den);
        if (b == 0)
            b = 1;
        if (d == 0)
            d = 1;
        if (c.kind == KIND_ADD)
        begin
            n = a * d + b * rc;
            m = b * d;
        end
        else if (c.kind == KIND_MUL)
        begin
            n = a * rc;
            m = b * d;
        end
        else
        begin
            n = a;
            m = b;
        end
        un = (n < 0) ? 64'(-n) : 64'(n);
        um = (m < 0) ? 64'(-m) : 64'(m);
        x  = un;
        y  = um;
        while (y != 0)
        begin
            t = y;
            y = x % y;
            x = t;
        end
        if (x == 0)
            x = 1;
        un = un / x;
        um = um / x;
        r.result_num = (((n < 0) != (m < 0)) && un != 0) ? -$signed(un) : $signed(un);
        r.result_den = um[DEN_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Results are sampled at the edge that ends the strobe cycle.
    always @(posedge clk)
    begin
        res_t w;
        if (rst_n && result_valid)
        begin
            if (fraction_q.size() == 0)
                report_mismatch("unexpected result", result.result_num, 0);
            else
            begin
                w = fraction_q.pop_front();
                if (result.result_num !== w.result_num)
                    report_mismatch("result_num", result.result_num, w.result_num);
                if (result.result_den !== w.result_den)
                    report_mismatch("result_den", 64'(result.result_den),
                                    64'(w.result_den));
                n_checked++;
            end
        end
    end

    // One transaction: hold start until taken, wait until busy falls, then predict.
    // start stays high afterwards while busy; the next idle cycle or the
    // caller drops it.
    task automatic send_cmd(input cmd_t c, input bit has_typed, input res_t typed);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (has_typed && typed != reduce_fraction(c))
            report_mismatch("typed row vs predictor", typed.result_num,
                            reduce_fraction(c).result_num);
        fraction_q.push_back(has_typed ? typed : reduce_fraction(c));
        n_sent++;
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(20)) - 10);
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    typedef struct {
        cmd_t c;
        bit   has_typed;
        res_t typed;
    } row_t;

    initial
    begin
        row_t rows[$];
        cmd_t c;
        int   idle_set[4];
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        errors    = 0;
        n_sent    = 0;
        n_checked = 0;
        idle_pct  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // kind, ln, ld, rn, rd, typed?, num, den
        rows.push_back('{'{KIND_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3}, 1, '{64'sd5, 62'd6}});
        rows.push_back('{'{KIND_MUL, 32'sd2, 32'sd3, -32'sd3, 32'sd4}, 1, '{-64'sd1, 62'd2}});
        rows.push_back('{'{2'd2, 32'sd4, -32'sd8, 32'sd7, 32'sd9}, 1, '{-64'sd1, 62'd2}});
        rows.push_back('{'{2'd3, -32'sd6, -32'sd9, 32'sd0, 32'sd0}, 1, '{64'sd2, 62'd3}});
        rows.push_back('{'{KIND_ADD, 32'sd5, 32'sd0, 32'sd1, 32'sd0}, 1, '{64'sd6, 62'd1}});
        rows.push_back('{'{KIND_MUL, 32'sd0, 32'sd7, 32'sd3, -32'sd5}, 1, '{64'sd0, 62'd1}});
        rows.push_back('{'{2'd2, 32'sd0, 32'sd0, 32'sd1, 32'sd1}, 1, '{64'sd0, 62'd1}});
        rows.push_back('{'{KIND_ADD, 32'sd1, 32'sd2, -32'sd1, 32'sd2}, 1, '{64'sd0, 62'd1}});
        rows.push_back('{'{KIND_MUL, 32'h7fff_ffff, 32'sd1, 32'h7fff_ffff, 32'sd1}, 1,
                         '{64'sd4611686014132420609, 62'd1}});
        rows.push_back('{'{KIND_MUL, 32'sd1, 32'h7fff_ffff, 32'sd1, 32'h8000_0000}, 1,
                         '{-64'sd1, 62'd4611686014132420609}});
        rows.push_back('{'{2'd2, 32'h8000_0000, 32'sd1, 32'sd0, 32'sd0}, 1,
                         '{-64'sd2147483647, 62'd1}});
        rows.push_back('{'{KIND_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff}, 1, '{64'sd2, 62'd1}});
        rows.push_back('{'{KIND_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                          32'h8000_0000}, 0, '0});
        rows.push_back('{'{KIND_ADD, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa,
                          32'h1234_5678}, 0, '0});
        rows.push_back('{'{KIND_MUL, 32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555,
                          32'haaaa_aaaa}, 0, '0});
        rows.push_back('{'{2'd2, 32'sd30, 32'sd0, 32'sd0, 32'sd0}, 1, '{64'sd30, 62'd1}});
        foreach (rows[i])
            send_cmd(rows[i].c, rows[i].has_typed, rows[i].typed);
        start <= 1'b0;

        // Hold off until everything is back.
        while (fraction_q.size() != 0)
            @(posedge clk);

        idle_set = '{0, 59, 59, 37};
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_set[ph];
            for (int k = 0; k < 185; k++)
            begin
                c.kind      = 2'($urandom_range(3));
                c.left_num  = rand_field();
                c.left_den  = rand_field();
                c.right_num = rand_field();
                c.right_den = rand_field();
                send_cmd(c, 0, '0);
            end
        end
        start <= 1'b0;

        while (fraction_q.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        $display("%0d transactions sent, %0d results checked over four idle phases",
                 n_sent, n_checked);
        if (errors == 0 && fraction_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
